// ===== hdl/s256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package s256_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] chain_type;

   localparam int ROUNDS = 64;

   // Transaction kinds on the request channel.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Padding marker, start of the length field and last byte of a block.
   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [5:0] LAST_FILL = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;

   // Initial hash values; element 0 is the first word of the digest.
   localparam chain_type INIT_H = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   // Round constants.
   localparam logic [31:0] K_TABLE [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_PCOMP,
      ST_LEN,
      ST_FCOMP,
      ST_OUT
   } state_type;

   // Commands from the sequencer to the compression core.
   typedef struct packed {
      logic       wr_en;
      logic [5:0] wr_idx;
      logic [7:0] wr_byte;
      logic       start;
      logic       reinit;
   } core_ctrl_type;

   // Status from the compression core.
   typedef struct packed {
      logic busy;
      logic done;
   } core_status_type;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(input word_type e, input word_type f,
                                       input word_type g);
      choose = (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(input word_type a, input word_type b,
                                         input word_type c);
      majority = (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

// ===== hdl/s256_core.sv =====
// Block buffer, message schedule window and one-round-per-cycle compression unit.
`timescale 1ns / 1ps

module s256_core (
   input  logic                    clock,
   input  logic                    reset,
   input  s256_pkg::core_ctrl_type ctrl,
   output s256_pkg::core_status_type status,
   output s256_pkg::chain_type     chain_words
);
   import s256_pkg::*;

   chain_type  chain_ff;
   chain_type  var_ff;
   word_type   win_ff [16];
   logic [5:0] round_ff;
   logic       busy_ff;
   logic       fold_ff;

   word_type   t1;
   word_type   t2;
   word_type   w_new;
   logic [1:0] byte_lane;

   // One compression round and the next schedule word.
   always_comb begin
      t1 = var_ff[7] + big_sigma1(var_ff[4]) + choose(var_ff[4], var_ff[5], var_ff[6])
         + K_TABLE[round_ff] + win_ff[0];
      t2 = big_sigma0(var_ff[0]) + majority(var_ff[0], var_ff[1], var_ff[2]);
      w_new = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      byte_lane = 2'd3 - ctrl.wr_idx[1:0];
   end

   // The window holds the block bytes as big-endian words and then shifts as the schedule.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         win_ff[ctrl.wr_idx[5:2]][{byte_lane, 3'b000} +: 8] <= ctrl.wr_byte;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[15] <= w_new;
      end
   end

   // Working variables a to h.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         var_ff <= chain_ff;
      end else if (busy_ff) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

   // Round counter; the fold cycle follows the last round.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         fold_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         fold_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            round_ff <= round_ff + 6'd1;
            if (round_ff == 6'(ROUNDS - 1)) begin
               busy_ff <= 1'b0;
               fold_ff <= 1'b1;
            end
         end
      end
   end

   // Chaining words: folded after each block, restored after each digest.
   always_ff @(posedge clock) begin
      if (reset || ctrl.reinit) begin
         chain_ff <= INIT_H;
      end else if (fold_ff) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = fold_ff;
   assign chain_words = chain_ff;

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer and digest output.
//
//   Channel | Ports                                                | Direction
//   --------+------------------------------------------------------+----------
//   req     | req_valid, req_stall, req_kind, req_data_byte        | in
//   rsp     | rsp_valid, rsp_stall, rsp_digest_word, rsp_word_index, rsp_last_word | out
//
// Data bytes are taken one per cycle while the sequencer is idle; the 64th byte of a block
// starts 64 rounds of the shared round unit and a fold, during which requests stall.
// A finish transaction writes padding and length one byte per cycle outside compressions
// (up to 72 bytes, and a step without a write where the zero run meets the length field),
// runs one or two compressions and offers the eight digest words, one per unstalled cycle.
// Reset is synchronous and restores the initial hash values, fill count and length.
// Request stall is high whenever the sequencer is not idle; response stall holds the
// current digest word in place.
`timescale 1ns / 1ps

module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import s256_pkg::*;

   state_type       state_ff;
   state_type       state_in;
   logic [5:0]      fill_ff;
   logic [5:0]      fill_in;
   logic [63:0]     bits_ff;
   logic [63:0]     bits_in;
   logic [2:0]      out_idx_ff;
   logic [2:0]      out_idx_in;

   logic            req_accept;
   logic            rsp_accept;
   logic [7:0]      len_byte;
   core_ctrl_type   core_ctrl;
   core_status_type core_status;
   chain_type       chain_words;

   s256_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (core_ctrl),
      .status      (core_status),
      .chain_words (chain_words)
   );

   assign req_accept = req_valid & ~req_stall;
   assign rsp_accept = rsp_valid & ~rsp_stall;

   // Length bytes go out most significant first at block positions 56 to 63.
   assign len_byte = bits_ff[{~fill_ff[2:0], 3'b000} +: 8];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_kind == KIND_DATA) begin
                  state_in = (fill_ff == LAST_FILL) ? ST_COMP : ST_IDLE;
               end else begin
                  state_in = (fill_ff == LAST_FILL) ? ST_PCOMP : ST_PAD;
               end
            end
         end
         ST_COMP: begin
            if (core_status.done) state_in = ST_IDLE;
         end
         ST_PAD: begin
            if (fill_ff == LEN_POS) begin
               state_in = ST_LEN;
            end else if (fill_ff == LAST_FILL) begin
               state_in = ST_PCOMP;
            end
         end
         ST_PCOMP: begin
            if (core_status.done) state_in = ST_PAD;
         end
         ST_LEN: begin
            if (fill_ff == LAST_FILL) state_in = ST_FCOMP;
         end
         ST_FCOMP: begin
            if (core_status.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_accept && out_idx_ff == LAST_WORD) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: handshakes and commands to the core.
   always_comb begin
      core_ctrl        = '0;
      core_ctrl.wr_idx = fill_ff;
      req_stall        = 1'b1;
      rsp_valid        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_accept) begin
               core_ctrl.wr_en   = 1'b1;
               core_ctrl.wr_byte = (req_kind == KIND_DATA) ? req_data_byte : PAD_BYTE;
               core_ctrl.start   = (fill_ff == LAST_FILL);
            end
         end
         ST_PAD: begin
            if (fill_ff != LEN_POS) begin
               core_ctrl.wr_en   = 1'b1;
               core_ctrl.wr_byte = ZERO_BYTE;
               core_ctrl.start   = (fill_ff == LAST_FILL);
            end
         end
         ST_LEN: begin
            core_ctrl.wr_en   = 1'b1;
            core_ctrl.wr_byte = len_byte;
            core_ctrl.start   = (fill_ff == LAST_FILL);
         end
         ST_OUT: begin
            rsp_valid        = 1'b1;
            core_ctrl.reinit = rsp_accept && (out_idx_ff == LAST_WORD);
         end
         default: begin
            core_ctrl = core_ctrl;
         end
      endcase
   end

   // Fill count, message length and digest word pointer.
   always_comb begin
      fill_in    = fill_ff;
      bits_in    = bits_ff;
      out_idx_in = out_idx_ff;
      if (core_ctrl.wr_en) begin
         fill_in = fill_ff + 6'd1;
      end
      if (req_accept && req_kind == KIND_DATA) begin
         bits_in = bits_ff + 64'd8;
      end
      if (rsp_accept) begin
         out_idx_in = out_idx_ff + 3'd1;
      end
      if (core_ctrl.reinit) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         bits_ff    <= '0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         bits_ff    <= bits_in;
         out_idx_ff <= out_idx_in;
      end
   end

   assign rsp_digest_word = chain_words[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == LAST_WORD);

   // The request side is closed while digest words are offered.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while digest is offered");

   // The core never computes while the sequencer is idle.
   a_core_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !core_status.busy)
      else $error("core busy in idle state");

   // The 64th data byte hands the block to the core.
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == KIND_DATA && fill_ff == LAST_FILL)
      |=> (state_ff == ST_COMP && core_status.busy))
      else $error("full block not compressed");

   // Digest words leave in order.
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_last_word) |=> (rsp_valid
      && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word out of order");

   // After the last word the message state is back at its initial value.
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last_word) |=> (fill_ff == 6'd0 && bits_ff == 64'd0
      && state_ff == ST_IDLE))
      else $error("state not restored after digest");

endmodule

// ===== tb/sv/tb_sha256_stream_hasher.sv =====
// Self-checking testbench of the SHA-256 stream hasher with a digest-predicting scoreboard.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

   import s256_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 200;

   // Round constants and initial chaining words of SHA-256.
   localparam bit [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam bit [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // One digest word as it should appear on the response channel.
   typedef struct {
      bit [31:0] word;
      bit [2:0]  index;
      bit        last;
   } digest_beat_type;

   // Scoreboard: predicts the digest of each message and checks the response beats.
   class digest_scoreboard;
      bit [31:0]       chain [8];
      bit [7:0]        block_bytes [64];
      int unsigned     fill;
      bit [63:0]       bit_count;
      digest_beat_type awaited_words [$];
      int unsigned     fail_count;

      function new();
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         chain     = IV_WORDS;
         fill      = 0;
         bit_count = '0;
      endfunction

      function bit [31:0] ror32(input bit [31:0] x, input int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      // One 64-round compression of the current block into the chaining words.
      function void fold_block();
         bit [31:0] sched [64];
         bit [31:0] v [8];
         bit [31:0] s0;
         bit [31:0] s1;
         bit [31:0] t1;
         bit [31:0] t2;
         for (int i = 0; i < 16; i++) begin
            sched[i] = {block_bytes[4*i], block_bytes[4*i+1],
                        block_bytes[4*i+2], block_bytes[4*i+3]};
         end
         for (int i = 16; i < 64; i++) begin
            s0 = ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
         end
         v = chain;
         for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + sched[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) begin
            chain[i] += v[i];
         end
      endfunction

      // Updates the hash state with an accepted request transaction.
      function void note_request(input logic kind, input logic [7:0] data);
         digest_beat_type beat;
         if (kind == KIND_DATA) begin
            block_bytes[fill] = data;
            fill++;
            bit_count += 64'd8;
            if (fill == 64) begin
               fold_block();
               fill = 0;
            end
         end else begin
            // Padding marker, then an extra block when the length no longer fits.
            block_bytes[fill] = 8'h80;
            fill++;
            if (fill > 56) begin
               while (fill < 64) begin
                  block_bytes[fill] = 8'h00;
                  fill++;
               end
               fold_block();
               fill = 0;
            end
            while (fill < 56) begin
               block_bytes[fill] = 8'h00;
               fill++;
            end
            for (int i = 0; i < 8; i++) begin
               block_bytes[56+i] = bit_count[63-8*i -: 8];
            end
            fold_block();
            for (int i = 0; i < 8; i++) begin
               beat.word  = chain[i];
               beat.index = i[2:0];
               beat.last  = (i == 7);
               awaited_words.push_back(beat);
            end
            restart();
         end
      endfunction

      // Compares an accepted response transaction with the oldest awaited word.
      function void check_beat(input logic [31:0] word, input logic [2:0] index,
                               input logic last);
         digest_beat_type beat;
         if (awaited_words.size() == 0) begin
            $error("Unexpected digest word %h (index %0d) with none awaited", word, index);
            fail_count++;
            return;
         end
         beat = awaited_words.pop_front();
         if (word !== beat.word) begin
            $error("digest_word: expected %h, actual %h", beat.word, word);
            fail_count++;
         end
         if (index !== beat.index) begin
            $error("word_index: expected %0d, actual %0d", beat.index, index);
            fail_count++;
         end
         if (last !== beat.last) begin
            $error("last_word: expected %0d, actual %0d", beat.last, last);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return awaited_words.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_scoreboard sb;
   bit               idle_on;
   int unsigned      stall_left;
   logic             stall_next;
   int unsigned      cycle_count;

   sha256_stream_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // Free-running clock.
   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: check each accepted word and stall in random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_beat(rsp_digest_word, rsp_word_index, rsp_last_word);
         end
         if (stall_left != 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // Offers one request transaction, with an optional idle burst before it.
   task automatic push_item(input logic kind, input logic [7:0] data);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, data);
   endtask

   // A message of random bytes closed by a finish with a random ignored byte.
   task automatic push_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         push_item(KIND_DATA, 8'($urandom_range(0, 255)));
      end
      push_item(KIND_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // Holds the request side idle until every awaited digest word has arrived.
   task automatic drain_digests();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Stimulus sequence.
   initial begin
      int unsigned edge_len [2];
      edge_len = '{60, 64};
      sb            = new();
      idle_on       = 1'b1;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_DATA;
      req_data_byte = 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty messages back to back; the byte on a finish is ignored.
      push_item(KIND_FINISH, 8'h00);
      push_item(KIND_FINISH, 8'hff);
      // The classic three-byte message.
      push_item(KIND_DATA, 8'h61);
      push_item(KIND_DATA, 8'h62);
      push_item(KIND_DATA, 8'h63);
      push_item(KIND_FINISH, 8'h5a);
      // Extreme byte values.
      push_item(KIND_DATA, 8'h00);
      push_item(KIND_DATA, 8'hff);
      push_item(KIND_DATA, 8'h80);
      push_item(KIND_DATA, 8'h7f);
      push_item(KIND_DATA, 8'h01);
      push_item(KIND_FINISH, 8'ha5);
      push_item(KIND_DATA, 8'hff);
      push_item(KIND_FINISH, 8'h80);

      drain_digests();

      // One length that needs an extra padding block and one that fills a whole block.
      foreach (edge_len[i]) begin
         push_message(edge_len[i]);
         push_message($urandom_range(0, 4));
      end
      drain_digests();
      repeat (2) push_message($urandom_range(0, 8));

      // Closing stretch without idling on either side.
      idle_on = 1'b0;
      push_message($urandom_range(0, 12));
      push_message(3);
      req_valid <= 1'b0;

      do @(posedge clock); while (sb.pending() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
